### sv/ecb_pkg.sv
// ============================================================================
// ecb_pkg: shared types, constants and helpers of the camera basis unit
// Holds the fixed-point formats, the arctangent table of the CORDIC and the
// operation codes of the serial arithmetic unit.
// ============================================================================
package ecb_pkg;

  // Sizes that follow from the field widths and the fixed-point formats.
  localparam int CORDIC_STEPS  = 16;
  localparam int VEC_FRAC_BITS = 14;
  localparam int CORDIC_RUN    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int OUT_SHIFT     = 30 - VEC_FRAC_BITS;

  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [32:0] ONE_Q30     = 33'd1073741824;
  localparam int          PITCH_LIMIT = 4147701;

  // Operation codes of the serial arithmetic unit.
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_SQRT = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  // Item selector codes.
  localparam logic [1:0] FUNC_YAW   = 2'd0;
  localparam logic [1:0] FUNC_PITCH = 2'd1;
  localparam logic [1:0] FUNC_MOUSE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOCK   = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_MARGIN = 2'd2;

  // A Q30 vector component with head room for the CORDIC gain.
  typedef logic signed [33:0] vec_t;

  // Request to the serial arithmetic unit.
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } ser_ctl_t;

  function automatic vec_t atan_q30(input logic [4:0] i);
    vec_t a;
    case (i)
      5'd0:    a = 34'sd536870912;
      5'd1:    a = 34'sd316933406;
      5'd2:    a = 34'sd167458907;
      5'd3:    a = 34'sd85004756;
      5'd4:    a = 34'sd42667331;
      5'd5:    a = 34'sd21354465;
      5'd6:    a = 34'sd10679838;
      5'd7:    a = 34'sd5340245;
      5'd8:    a = 34'sd2670163;
      5'd9:    a = 34'sd1335087;
      5'd10:   a = 34'sd667544;
      5'd11:   a = 34'sd333772;
      5'd12:   a = 34'sd166886;
      5'd13:   a = 34'sd83443;
      5'd14:   a = 34'sd41722;
      5'd15:   a = 34'sd20861;
      5'd16:   a = 34'sd10430;
      5'd17:   a = 34'sd5215;
      5'd18:   a = 34'sd2608;
      5'd19:   a = 34'sd1304;
      5'd20:   a = 34'sd652;
      5'd21:   a = 34'sd326;
      5'd22:   a = 34'sd163;
      5'd23:   a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [32:0] mag33(input vec_t v);
    vec_t n;
    n = -v;
    return v[33] ? n[32:0] : v[32:0];
  endfunction

  // Q30 to output format: round half up, then saturate to plus or minus one.
  function automatic logic [15:0] to_out(input vec_t v);
    logic signed [34:0] t;
    logic signed [34:0] lim;
    t   = ($signed({v[33], v}) + (35'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    lim = 35'sd1 <<< VEC_FRAC_BITS;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t[15:0];
  endfunction

endpackage

### sv/ecb_if.sv
// ============================================================================
// ecb_if: stream interfaces of the camera basis unit
// Item channel and result channel, each with valid, ready and payload.
// ============================================================================
interface ecb_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic signed [23:0] angle_delta;
  logic signed [31:0] mouse_x;
  logic signed [31:0] mouse_y;

  modport source (output valid, func, angle_delta, mouse_x, mouse_y, input ready);
  modport sink   (input valid, func, angle_delta, mouse_x, mouse_y, output ready);
endinterface

interface ecb_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] forward_x;
  logic signed [15:0] forward_y;
  logic signed [15:0] forward_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic        [23:0] yaw_now;
  logic signed [22:0] pitch_now;
  logic               ignored;

  modport source (output valid, forward_x, forward_y, forward_z, right_x, right_y,
                  right_z, up_x, up_y, up_z, yaw_now, pitch_now, ignored,
                  input ready);
  modport sink   (input valid, forward_x, forward_y, forward_z, right_x, right_y,
                  right_z, up_x, up_y, up_z, yaw_now, pitch_now, ignored,
                  output ready);
endinterface

### sv/ecb_serial.sv
// ============================================================================
// ecb_serial: bit-serial multiply, square root and divide
// Shift-add multiply (one multiplier bit a cycle), digit-by-digit square
// root (two radicand bits a cycle) and restoring division (one bit a cycle).
// ============================================================================
module ecb_serial (
  input  logic              clk,
  input  logic              rst,
  input  ecb_pkg::ser_ctl_t ctl,
  input  logic [63:0]       opa,
  input  logic [32:0]       opb,
  output logic [63:0]       res,
  output logic              done
);
  import ecb_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [1:0]  op;
  logic [32:0] mcand;
  logic [32:0] hi;
  logic [32:0] lo;
  logic [63:0] nsh;
  logic [33:0] rem;
  logic [31:0] root;
  logic [31:0] quo;
  logic [32:0] dvs;

  logic [33:0] msum;
  logic [35:0] sq_sh;
  logic [35:0] sq_trial;
  logic [33:0] dv_sh;
  logic [5:0]  last;

  always_comb begin
    msum     = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : 34'd0);
    sq_sh    = {rem, nsh[63:62]};
    sq_trial = {2'b00, root, 2'b01};
    dv_sh    = {rem[32:0], nsh[63]};
    last     = (op == OP_MUL) ? 6'd32 : 6'd31;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= OP_MUL;
    end else begin
      done <= busy && !ctl.start && (cnt == last);
      if (ctl.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        op    <= ctl.op;
        mcand <= opa[32:0];
        hi    <= '0;
        lo    <= opb;
        dvs   <= opb;
        root  <= '0;
        quo   <= '0;
        if (ctl.op == OP_DIV) begin
          nsh <= {opa[31:0], 32'd0};
          rem <= {2'b00, opa[63:32]};
        end else begin
          nsh <= opa;
          rem <= '0;
        end
      end else if (busy) begin
        case (op)
          OP_MUL: begin
            hi <= msum[33:1];
            lo <= {msum[0], lo[32:1]};
          end
          OP_SQRT: begin
            if (sq_sh >= sq_trial) begin
              rem  <= 34'(sq_sh - sq_trial);
              root <= {root[30:0], 1'b1};
            end else begin
              rem  <= sq_sh[33:0];
              root <= {root[30:0], 1'b0};
            end
            nsh <= {nsh[61:0], 2'b00};
          end
          OP_DIV: begin
            if (dv_sh >= {1'b0, dvs}) begin
              rem <= 34'(dv_sh - {1'b0, dvs});
              quo <= {quo[30:0], 1'b1};
            end else begin
              rem <= dv_sh;
              quo <= {quo[30:0], 1'b0};
            end
            nsh <= {nsh[62:0], 1'b0};
          end
          default: ;
        endcase
        cnt <= cnt + 6'd1;
        if (cnt == last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    case (op)
      OP_MUL:  res = {hi[30:0], lo};
      OP_SQRT: res = {32'd0, root};
      OP_DIV:  res = {32'd0, quo};
      default: res = '0;
    endcase
  end

endmodule

### sv/ecb_cordic.sv
// ============================================================================
// ecb_cordic: iterative rotation-mode CORDIC for sine and cosine
// Folds the angle into plus or minus a quarter turn, then runs one
// micro-rotation a cycle on Q30 values.
// ============================================================================
module ecb_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   angle,
  output ecb_pkg::vec_t cos_o,
  output ecb_pkg::vec_t sin_o,
  output logic          done
);
  import ecb_pkg::*;

  logic       busy;
  logic [4:0] step;
  logic       flip;
  vec_t       x;
  vec_t       y;
  vec_t       z;
  logic       fold;
  logic [31:0] a2;
  vec_t       xs;
  vec_t       ys;
  vec_t       at;

  always_comb begin
    fold = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
    a2   = fold ? {~angle[31], angle[30:0]} : angle;
    xs   = x >>> step;
    ys   = y >>> step;
    at   = atan_q30(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == 5'(CORDIC_RUN - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        flip <= fold;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= {{2{a2[31]}}, a2};
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        step <= step + 5'd1;
        if (step == 5'(CORDIC_RUN - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign cos_o = flip ? -x : x;
  assign sin_o = flip ? -y : y;

endmodule

### sv/euler_camera_basis_unit.sv
// ============================================================================
// euler_camera_basis_unit: yaw/pitch camera orientation with unit basis
// Keeps a wrapping yaw and a clamped pitch, applies delta and mouse
// transactions, and returns forward, right and up vectors in Q1.14.
// ============================================================================
//
//  Channel  Direction  Handshake           Payload
//  req      in         valid/ready         func, angle_delta, mouse_x, mouse_y
//  rsp      out        valid/ready         forward/right/up xyz, yaw_now,
//                                          pitch_now, ignored
//  apb      in         psel/penable/pready target_locked, mouse_gain,
//                                          up_switch_margin
//
//  One transaction in gives one transaction out, registered in the output
//  state after it is accepted; the next one is taken in the following cycle.
//  The work runs in turn on the shared bit-serial unit, 14 multiplies, two
//  square roots and six divisions (skipped for a zero-length vector), plus
//  two CORDIC runs and the scale, apply, select and output steps.
//  Reset is synchronous and active high; it restores the angles, the mouse
//  history and the registers to their defaults. A result that is not taken
//  waits in the output register while the next transaction is accepted and
//  worked on; only the hand-over of that next result waits for it.
//
module euler_camera_basis_unit (
  input  logic        clk,
  input  logic        rst,
  ecb_req_if.sink     req,
  ecb_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ecb_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCALE = 4'd1;
  localparam logic [3:0] ST_APPLY = 4'd2;
  localparam logic [3:0] ST_CORY  = 4'd3;
  localparam logic [3:0] ST_CORP  = 4'd4;
  localparam logic [3:0] ST_FMUL  = 4'd5;
  localparam logic [3:0] ST_SEL   = 4'd6;
  localparam logic [3:0] ST_NSQ   = 4'd7;
  localparam logic [3:0] ST_NSQRT = 4'd8;
  localparam logic [3:0] ST_NDIV  = 4'd9;
  localparam logic [3:0] ST_XMUL  = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  // Configuration registers.
  logic        target_locked;
  logic [15:0] mouse_gain;
  logic [14:0] up_switch_margin;

  // Camera state.
  logic        [23:0] yaw_angle;
  logic signed [22:0] pitch_angle;
  logic signed [31:0] last_mouse_x;
  logic signed [31:0] last_mouse_y;
  logic               first_mouse;

  // The transaction being worked on.
  logic        [1:0]  func;
  logic signed [23:0] angle_delta;
  logic signed [31:0] mouse_x;
  logic signed [31:0] mouse_y;
  logic               ignored;
  logic signed [49:0] prod_x;
  logic signed [49:0] prod_y;

  // Sequencer.
  logic [3:0] state;
  logic [2:0] idx;
  logic       wait_unit;
  logic       pass;

  // Working vectors, all Q30.
  vec_t cy, sy, cp;
  vec_t fvec [3];
  vec_t vin  [3];
  vec_t rvec [3];
  vec_t uvec [3];
  vec_t        ny;
  logic [63:0] sum;
  logic [31:0] len;
  logic signed [63:0] pa;

  // ---------------------------------------------------------------------
  // Configuration port. Writes land on the access cycle.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_locked    <= 1'b0;
      mouse_gain       <= 16'd26702;
      up_switch_margin <= 15'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LOCK:   target_locked    <= pwdata[0];
        REG_GAIN:   mouse_gain       <= pwdata[15:0];
        REG_MARGIN: up_switch_margin <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOCK:   prdata = {31'd0, target_locked};
      REG_GAIN:   prdata = {16'd0, mouse_gain};
      REG_MARGIN: prdata = {17'd0, up_switch_margin};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Shared units: one CORDIC for both angles, one serial arithmetic unit
  // for every vector product, square root and quotient; the mouse scaling has its own.
  // ---------------------------------------------------------------------
  logic        cor_go;
  logic [31:0] cor_angle;
  vec_t        cor_cos, cor_sin;
  logic        cor_done;

  assign cor_go    = !wait_unit && ((state == ST_CORY) || (state == ST_CORP));
  assign cor_angle = (state == ST_CORY) ? {yaw_angle, 8'd0}
                                        : {pitch_angle[22], pitch_angle, 8'd0};

  ecb_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_go),
    .angle (cor_angle),
    .cos_o (cor_cos),
    .sin_o (cor_sin),
    .done  (cor_done)
  );

  ser_ctl_t    ser_ctl;
  logic [63:0] ser_a;
  logic [32:0] ser_b;
  logic [63:0] ser_res;
  logic        ser_done;

  vec_t        op_a, op_b;
  logic        neg;
  logic [63:0] num;
  logic signed [63:0] prod;
  logic signed [63:0] diff;
  logic signed [63:0] prod_sh;
  logic signed [63:0] diff_sh;
  logic [33:0] qsig;

  // Operand selection for the multiply states.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_FMUL: begin
        op_a = idx[0] ? sy : cy;
        op_b = cp;
      end
      ST_NSQ: begin
        op_a = vin[idx[1:0]];
        op_b = vin[idx[1:0]];
      end
      ST_XMUL: begin
        case (idx)
          3'd0: begin op_a = rvec[1]; op_b = fvec[2]; end
          3'd1: begin op_a = rvec[2]; op_b = fvec[1]; end
          3'd2: begin op_a = rvec[2]; op_b = fvec[0]; end
          3'd3: begin op_a = rvec[0]; op_b = fvec[2]; end
          3'd4: begin op_a = rvec[0]; op_b = fvec[1]; end
          3'd5: begin op_a = rvec[1]; op_b = fvec[0]; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    neg = op_a[33] ^ op_b[33];
    num = {1'b0, mag33(vin[idx[1:0]]), 30'd0} + {33'd0, len[31:1]};
    ser_ctl.op = OP_MUL;
    ser_a      = {31'd0, mag33(op_a)};
    ser_b      = mag33(op_b);
    case (state)
      ST_NSQRT: begin
        ser_ctl.op = OP_SQRT;
        ser_a      = sum;
        ser_b      = '0;
      end
      ST_NDIV: begin
        ser_ctl.op = OP_DIV;
        ser_a      = num;
        ser_b      = {1'b0, len};
      end
      default: ;
    endcase
    ser_ctl.start = !wait_unit &&
                    ((state == ST_FMUL) || (state == ST_NSQ) || (state == ST_NSQRT) ||
                     (state == ST_XMUL) || ((state == ST_NDIV) && (len != 32'd0)));
  end

  ecb_serial u_serial (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ser_ctl),
    .opa  (ser_a),
    .opb  (ser_b),
    .res  (ser_res),
    .done (ser_done)
  );

  // Signed views of the unit's results.
  always_comb begin
    prod    = neg ? -$signed(ser_res) : $signed(ser_res);
    diff    = pa - prod;
    prod_sh = prod >>> 30;
    diff_sh = diff >>> 30;
    qsig    = vin[idx[1:0]][33] ? -{2'b00, ser_res[31:0]} : {2'b00, ser_res[31:0]};
    ny      = fvec[1];
  end

  // ---------------------------------------------------------------------
  // Angle update.
  // ---------------------------------------------------------------------
  logic signed [50:0] rnd_x, rnd_y;
  logic signed [42:0] scl_x, scl_y;
  logic signed [42:0] pitch_d;
  logic signed [43:0] pitch_sum;
  logic signed [22:0] pitch_clamped;
  logic               do_yaw, do_pitch;
  logic        [23:0] yaw_d;

  always_comb begin
    rnd_x = {prod_x[49], prod_x} + 51'sd128;
    rnd_y = {prod_y[49], prod_y} + 51'sd128;
    scl_x = 43'(rnd_x >>> 8);
    scl_y = 43'(rnd_y >>> 8);
    do_yaw   = 1'b0;
    do_pitch = 1'b0;
    yaw_d    = angle_delta;
    pitch_d  = {{19{angle_delta[23]}}, angle_delta};
    case (func)
      FUNC_YAW: do_yaw = !target_locked;
      FUNC_PITCH: do_pitch = !target_locked;
      FUNC_MOUSE: begin
        // The first mouse transaction only records where the pointer is.
        do_yaw   = !first_mouse;
        do_pitch = !first_mouse;
        yaw_d    = scl_x[23:0];
        pitch_d  = scl_y;
      end
      default: ;
    endcase
    pitch_sum = {{21{pitch_angle[22]}}, pitch_angle} + {pitch_d[42], pitch_d};
    if (pitch_sum > 44'sd4147701)
      pitch_clamped = 23'sd4147701;
    else if (pitch_sum < -44'sd4147701)
      pitch_clamped = -23'sd4147701;
    else
      pitch_clamped = pitch_sum[22:0];
  end

  // World up switches to +z when forward is nearly vertical.
  logic [32:0]        fy_abs;
  logic signed [34:0] up_gap;
  logic               up_is_z;

  always_comb begin
    fy_abs  = mag33(ny);
    up_gap  = $signed({2'b00, ONE_Q30}) - $signed({2'b00, fy_abs});
    up_is_z = up_gap < $signed({4'd0, up_switch_margin, 16'd0});
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      wait_unit    <= 1'b0;
      pass         <= 1'b0;
      yaw_angle    <= '0;
      pitch_angle  <= '0;
      last_mouse_x <= '0;
      last_mouse_y <= '0;
      first_mouse  <= 1'b1;
      rsp.valid    <= 1'b0;
    end else begin
      // In the output state the hand-over below decides the flag itself.
      if (rsp.valid && rsp.ready && (state != ST_OUT)) rsp.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            func        <= req.func;
            angle_delta <= req.angle_delta;
            mouse_x     <= req.mouse_x;
            mouse_y     <= req.mouse_y;
            state       <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          prod_x <= ($signed({last_mouse_x[31], last_mouse_x}) -
                     $signed({mouse_x[31], mouse_x})) * $signed({1'b0, mouse_gain});
          prod_y <= ($signed({mouse_y[31], mouse_y}) -
                     $signed({last_mouse_y[31], last_mouse_y})) * $signed({1'b0, mouse_gain});
          state  <= ST_APPLY;
        end
        ST_APPLY: begin
          ignored <= ((func == FUNC_YAW) || (func == FUNC_PITCH)) && target_locked;
          if (do_yaw) yaw_angle <= yaw_angle + yaw_d;
          if (do_pitch) pitch_angle <= pitch_clamped;
          if (func == FUNC_MOUSE) begin
            last_mouse_x <= mouse_x;
            last_mouse_y <= mouse_y;
            first_mouse  <= 1'b0;
          end
          wait_unit <= 1'b0;
          state     <= ST_CORY;
        end
        ST_CORY: begin
          if (!wait_unit) wait_unit <= 1'b1;
          else if (cor_done) begin
            cy        <= cor_cos;
            sy        <= cor_sin;
            wait_unit <= 1'b0;
            state     <= ST_CORP;
          end
        end
        ST_CORP: begin
          if (!wait_unit) wait_unit <= 1'b1;
          else if (cor_done) begin
            cp        <= cor_cos;
            fvec[1]   <= cor_sin;
            wait_unit <= 1'b0;
            idx       <= '0;
            state     <= ST_FMUL;
          end
        end
        ST_FMUL: begin
          if (!wait_unit) wait_unit <= 1'b1;
          else if (ser_done) begin
            wait_unit <= 1'b0;
            if (idx[0]) begin
              fvec[2] <= prod_sh[33:0];
              state   <= ST_SEL;
            end else begin
              fvec[0] <= prod_sh[33:0];
              idx     <= 3'd1;
            end
          end
        end
        ST_SEL: begin
          // Right is forward crossed with world up, before normalisation.
          if (up_is_z) begin
            vin[0] <= fvec[1];
            vin[1] <= -fvec[0];
            vin[2] <= '0;
          end else begin
            vin[0] <= -fvec[2];
            vin[1] <= '0;
            vin[2] <= fvec[0];
          end
          pass  <= 1'b0;
          sum   <= '0;
          idx   <= '0;
          state <= ST_NSQ;
        end
        ST_NSQ: begin
          if (!wait_unit) wait_unit <= 1'b1;
          else if (ser_done) begin
            wait_unit <= 1'b0;
            sum       <= sum + ser_res;
            if (idx == 3'd2) state <= ST_NSQRT;
            else idx <= idx + 3'd1;
          end
        end
        ST_NSQRT: begin
          if (!wait_unit) wait_unit <= 1'b1;
          else if (ser_done) begin
            wait_unit <= 1'b0;
            len       <= ser_res[31:0];
            idx       <= '0;
            state     <= ST_NDIV;
          end
        end
        ST_NDIV: begin
          // A zero-length vector normalises to the zero vector.
          if ((len == 32'd0) || (wait_unit && ser_done)) begin
            wait_unit <= 1'b0;
            if (pass) uvec[idx[1:0]] <= (len == 32'd0) ? '0 : qsig;
            else      rvec[idx[1:0]] <= (len == 32'd0) ? '0 : qsig;
            if (idx == 3'd2) begin
              idx   <= '0;
              state <= pass ? ST_OUT : ST_XMUL;
            end else begin
              idx <= idx + 3'd1;
            end
          end else if (!wait_unit) begin
            wait_unit <= 1'b1;
          end
        end
        ST_XMUL: begin
          // Up is right crossed with forward; products are taken in pairs.
          if (!wait_unit) wait_unit <= 1'b1;
          else if (ser_done) begin
            wait_unit <= 1'b0;
            if (!idx[0]) pa <= prod;
            else vin[idx[2:1]] <= diff_sh[33:0];
            if (idx == 3'd5) begin
              pass  <= 1'b1;
              sum   <= '0;
              idx   <= '0;
              state <= ST_NSQ;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        ST_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.forward_x <= to_out(fvec[0]);
            rsp.forward_y <= to_out(fvec[1]);
            rsp.forward_z <= to_out(fvec[2]);
            rsp.right_x   <= to_out(rvec[0]);
            rsp.right_y   <= to_out(rvec[1]);
            rsp.right_z   <= to_out(rvec[2]);
            rsp.up_x      <= to_out(uvec[0]);
            rsp.up_y      <= to_out(uvec[1]);
            rsp.up_z      <= to_out(uvec[2]);
            rsp.yaw_now   <= yaw_angle;
            rsp.pitch_now <= pitch_angle;
            rsp.ignored   <= ignored;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
